FILE: hdl/morse_tree_decoder_top_defines.svh
// Assertion macros used by the Morse tree decoder top level.
`ifndef MORSE_TREE_DECODER_TOP_DEFINES_SVH
`define MORSE_TREE_DECODER_TOP_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define MTD_ASSERT_ALWAYS(label, ck, rn, cond, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define MTD_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define MTD_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/mtd_pkg.sv
// Package with the codes, widths and constants of the Morse tree decoder.
`default_nettype none

package mtd_pkg;

    localparam int LETTER_W   = 8;
    localparam int CODE_BITS_W = 4;
    localparam int CODE_LEN_W = 3;
    localparam int SYMBOL_W   = 2;

    // Longest path an insert beat can describe, and the width of its node index.
    localparam int INS_MAX_LEN = 4;
    localparam int INS_IDX_W   = INS_MAX_LEN + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    localparam logic [SYMBOL_W-1:0] SYM_DOT  = 2'd0;
    localparam logic [SYMBOL_W-1:0] SYM_DASH = 2'd1;
    localparam logic [SYMBOL_W-1:0] SYM_LGAP = 2'd2;
    localparam logic [SYMBOL_W-1:0] SYM_WGAP = 2'd3;

    localparam logic [LETTER_W-1:0] SPACE_CHAR = 8'h20;

    // Input tdata layout, lowest bit first. The op selector travels on tuser.
    localparam int IN_TDATA_W   = 24;
    localparam int IN_BITS_LSB  = 0;
    localparam int IN_LEN_LSB   = 4;
    localparam int IN_LET_LSB   = 7;
    localparam int IN_SYM_LSB   = 15;

endpackage

`default_nettype wire

FILE: hdl/morse_tree_decoder_top.sv
// Top level of the Morse tree decoder: decode walk, result staging and output register.
//
// The block takes one beat per cycle on the s_ channel while s_tready is high.
// An insert beat (s_tuser op 0) writes a letter into the code tree at the node
// its dot/dash path reaches, if that path is no longer than MAX_CODE_LEN and
// INS_MAX_LEN, and gives no result. A decode beat (op 1) carries one symbol: a
// dot or dash moves down the tree, a letter gap emits the letter of the current
// node, a word gap emits a space and drops the following symbol, and s_tlast
// emits the current node's letter with m_tlast set and restarts at the root.
// Results leave on the m_ channel, one beat per character, m_tuser flagging a
// path deeper than MAX_CODE_LEN. A result is read synchronously from the letter
// store into the staging register, then passes through the output register to
// m_tvalid. A decode beat that yields two characters holds the staging register
// until its second character moves on, and the input waits until then; otherwise
// it takes one beat per cycle. While the output register waits on m_tready, the
// staging register still accepts one more beat. Reset returns the walk to the
// root and makes every store node read as zero at once, with no clearing pass.

`default_nettype none

`include "morse_tree_decoder_top_defines.svh"

module morse_tree_decoder_top #(
    parameter int MAX_CODE_LEN = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // code_bits [3:0], code_len [6:4], letter [14:7], symbol [16:15], zero [23:17]
    input  wire logic [23:0] s_tdata,
    input  wire logic        s_tlast,
    // op [0]
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // character [7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    // path_overflow [0]
    output logic             m_tuser
);

    localparam int AW = MAX_CODE_LEN + 1;
    localparam int INS_LIMIT = (MAX_CODE_LEN < mtd_pkg::INS_MAX_LEN) ?
                               MAX_CODE_LEN : mtd_pkg::INS_MAX_LEN;
    localparam logic [mtd_pkg::CODE_LEN_W-1:0] LEN_LIMIT = mtd_pkg::CODE_LEN_W'(INS_LIMIT);
    localparam logic [AW-1:0] ROOT = AW'(1);

    // Input fields.
    logic                                  in_op;
    logic [mtd_pkg::CODE_BITS_W-1:0]       in_code_bits;
    logic [mtd_pkg::CODE_LEN_W-1:0]        in_code_len;
    logic [mtd_pkg::LETTER_W-1:0]          in_letter;
    logic [mtd_pkg::SYMBOL_W-1:0]          in_symbol;

    assign in_op        = s_tuser;
    assign in_code_bits = s_tdata[mtd_pkg::IN_BITS_LSB +: mtd_pkg::CODE_BITS_W];
    assign in_code_len  = s_tdata[mtd_pkg::IN_LEN_LSB +: mtd_pkg::CODE_LEN_W];
    assign in_letter    = s_tdata[mtd_pkg::IN_LET_LSB +: mtd_pkg::LETTER_W];
    assign in_symbol    = s_tdata[mtd_pkg::IN_SYM_LSB +: mtd_pkg::SYMBOL_W];

    logic s_fire;
    logic ins_fire;
    logic dec_fire;

    assign s_fire   = s_tvalid && s_tready;
    assign ins_fire = s_fire && (in_op == mtd_pkg::OP_INSERT);
    assign dec_fire = s_fire && (in_op == mtd_pkg::OP_DECODE);

    // Insert path to heap index: a leading one above the path bits.
    logic [mtd_pkg::INS_IDX_W-1:0] ins_one;
    logic [mtd_pkg::INS_IDX_W-1:0] ins_idx;
    logic                          ins_ok;
    logic                          wr_en;

    assign ins_one = mtd_pkg::INS_IDX_W'(1) << in_code_len;
    assign ins_idx = ins_one | ({1'b0, in_code_bits} & (ins_one - mtd_pkg::INS_IDX_W'(1)));
    assign ins_ok  = (in_code_len <= LEN_LIMIT);
    assign wr_en   = ins_fire && ins_ok;

    // Decode walk state.
    logic [AW-1:0]                node_reg, node_next;
    logic                         skip_reg, skip_next;
    logic                         ovf_reg, ovf_next;
    logic [mtd_pkg::LETTER_W-1:0] root_letter_reg;

    logic          is_step;
    logic          is_lgap;
    logic          is_wgap;
    logic          deep;
    logic [AW-1:0] step_node;
    logic          step_ovf;
    logic          has_a;
    logic          load_s1;

    assign is_step = !skip_reg &&
                     ((in_symbol == mtd_pkg::SYM_DOT) || (in_symbol == mtd_pkg::SYM_DASH));
    assign is_lgap = !skip_reg && (in_symbol == mtd_pkg::SYM_LGAP);
    assign is_wgap = !skip_reg && (in_symbol == mtd_pkg::SYM_WGAP);
    assign deep    = node_reg[AW-1];

    // A step below the deepest level leaves the node and marks the path instead.
    assign step_node = (is_step && !deep) ? {node_reg[AW-2:0], in_symbol[0]} : node_reg;
    assign step_ovf  = ovf_reg || (is_step && deep);
    assign has_a     = is_lgap || is_wgap;

    always_comb
    begin
        node_next = node_reg;
        skip_next = skip_reg;
        ovf_next  = ovf_reg;
        if (dec_fire)
        begin
            if (s_tlast || is_lgap)
            begin
                node_next = ROOT;
                ovf_next  = 1'b0;
            end
            else
            begin
                node_next = step_node;
                ovf_next  = step_ovf;
            end
            skip_next = !s_tlast && is_wgap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_reg        <= ROOT;
            skip_reg        <= 1'b0;
            ovf_reg         <= 1'b0;
            root_letter_reg <= '0;
        end
        else
        begin
            node_reg <= node_next;
            skip_reg <= skip_next;
            ovf_reg  <= ovf_next;
            if (wr_en && (in_code_len == '0))
            begin
                root_letter_reg <= in_letter;
            end
        end
    end

    // The store is read at the node the symbol leaves the walk on.
    logic [mtd_pkg::LETTER_W-1:0] rd_data;

    mtd_store #(
        .ADDR_W (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (AW'(ins_idx)),
        .wr_data (in_letter),
        .rd_en   (dec_fire),
        .rd_addr (step_node),
        .rd_data (rd_data)
    );

    // Staging register: up to two pending characters of one decode beat.
    // Result a is the letter-gap letter or the word-gap space; result b is the
    // end-of-message letter.
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_a_reg, s1_a_next;
    logic                         s1_b_reg, s1_b_next;
    logic                         s1_a_space_reg;
    logic                         s1_b_root_reg;
    logic                         s1_ovf_reg;
    logic [mtd_pkg::LETTER_W-1:0] s1_root_reg;

    logic                         out_valid_reg, out_valid_next;
    logic [mtd_pkg::LETTER_W-1:0] out_char_reg;
    logic                         out_eom_reg;
    logic                         out_ovf_reg;

    logic                         out_free;
    logic                         s1_move;
    logic                         s1_one_left;
    logic [mtd_pkg::LETTER_W-1:0] mem_char;
    logic [mtd_pkg::LETTER_W-1:0] head_char;
    logic                         head_eom;
    logic                         head_ovf;

    assign out_free    = !out_valid_reg || m_tready;
    assign s1_move     = s1_valid_reg && out_free;
    assign s1_one_left = !(s1_a_reg && s1_b_reg);
    assign s_tready    = !s1_valid_reg || (s1_move && s1_one_left);
    assign load_s1     = dec_fire && (has_a || s_tlast);

    // A path that ran too deep reads as an empty node.
    assign mem_char = s1_ovf_reg ? '0 : rd_data;

    always_comb
    begin
        if (s1_a_reg)
        begin
            head_char = s1_a_space_reg ? mtd_pkg::SPACE_CHAR : mem_char;
            head_eom  = 1'b0;
            head_ovf  = !s1_a_space_reg && s1_ovf_reg;
        end
        else
        begin
            head_char = s1_b_root_reg ? s1_root_reg : mem_char;
            head_eom  = 1'b1;
            head_ovf  = !s1_b_root_reg && s1_ovf_reg;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_a_next     = s1_a_reg;
        s1_b_next     = s1_b_reg;
        if (s1_move)
        begin
            if (s1_one_left)
            begin
                s1_valid_next = 1'b0;
            end
            else
            begin
                s1_a_next = 1'b0;
            end
        end
        if (load_s1)
        begin
            s1_valid_next = 1'b1;
            s1_a_next     = has_a;
            s1_b_next     = s_tlast;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_a_reg      <= 1'b0;
            s1_b_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_a_reg      <= s1_a_next;
            s1_b_reg      <= s1_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_a_space_reg <= is_wgap;
            s1_b_root_reg  <= is_lgap;
            s1_ovf_reg     <= step_ovf;
            s1_root_reg    <= root_letter_reg;
        end
        if (s1_move)
        begin
            out_char_reg <= head_char;
            out_eom_reg  <= head_eom;
            out_ovf_reg  <= head_ovf;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_eom_reg;
    assign m_tuser  = out_ovf_reg;

    `MTD_ASSERT_ALWAYS(a_node_nonzero, clk, rst_n, node_reg != '0, "walk node left the tree")
    `MTD_ASSERT_IMPLIES(a_stage_nonempty, clk, rst_n, s1_valid_reg, s1_a_reg || s1_b_reg, "staging holds no result")
    `MTD_ASSERT_IMPLIES(a_ovf_char_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == '0, "overflow beat with nonzero character")
    `MTD_ASSERT_NEXT(a_last_to_root, clk, rst_n, dec_fire && s_tlast, (node_reg == ROOT) && !ovf_reg && !skip_reg, "walk not reset after final symbol")

endmodule

`default_nettype wire

FILE: hdl/mtd_store.sv
// Letter store of the code tree: one write port, one registered read port.
`default_nettype none

module mtd_store #(
    parameter int ADDR_W = 5
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [ADDR_W-1:0]            wr_addr,
    input  wire logic [mtd_pkg::LETTER_W-1:0] wr_data,
    input  wire logic                         rd_en,
    input  wire logic [ADDR_W-1:0]            rd_addr,
    output logic      [mtd_pkg::LETTER_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [mtd_pkg::LETTER_W-1:0] letter_mem [DEPTH];
    logic [mtd_pkg::LETTER_W-1:0] rd_word_reg;
    logic [DEPTH-1:0]             valid_reg;
    logic                         rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            letter_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= letter_mem[rd_addr];
        end
    end

    // Valid bits make a never-written node read as zero right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

`default_nettype wire
